[rtl/radial_spotlight_alpha_mask_unit_assert.svh]
// Assertion macros for the radial spotlight alpha mask unit.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef RADIAL_SPOTLIGHT_ALPHA_MASK_UNIT_ASSERT_SVH
`define RADIAL_SPOTLIGHT_ALPHA_MASK_UNIT_ASSERT_SVH

// same-cycle implication
`define RSAM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsam assertion failed");

// next-cycle implication
`define RSAM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsam assertion failed");

`endif

[rtl/rsam_pkg.sv]
// Shared types and constants for the radial spotlight alpha mask unit.
// No dependencies.
package rsam_pkg;

	localparam int MAP_COLS = 64;
	localparam int MAP_ROWS = 64;

	localparam int POS_W    = 6;
	localparam int CTR_W    = 10;
	localparam int RAD_W    = 9;
	localparam int ALPHA_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam int SPAN_W   = 12;
	localparam int DIFF_W   = 11;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int SQ_W     = 18;
	localparam int LEN_W    = SQ_W + 1;
	localparam int NUM_W    = LEN_W + 8;
	localparam int DIV_STEPS = 9;

	localparam logic [ALPHA_W-1:0] ALPHA_DARK = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_COL = 2'd0,
		REG_CENTER_ROW = 2'd1,
		REG_RADIUS     = 2'd2
	} cfg_reg_t;

endpackage

[rtl/radial_spotlight_alpha_mask_unit.sv]
// Radial spotlight alpha mask: one item per clock while the output is not stalled. The
// result passes through four arithmetic stages, a nine-stage
// restoring divider that forms (distance squared * 255) / radius squared one quotient bit
// per stage, and the output register. A stalled output freezes the whole pipeline.
// Depends on rsam_pkg.
module radial_spotlight_alpha_mask_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rsam_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rsam_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rsam_pkg::POS_W-1:0]          col,
	input  logic [rsam_pkg::POS_W-1:0]          row,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rsam_pkg::ALPHA_W-1:0]        alpha
);
	import rsam_pkg::*;

	logic signed [CTR_W-1:0] center_col_q;
	logic signed [CTR_W-1:0] center_row_q;
	logic        [RAD_W-1:0] radius_q;

	logic advance;

	logic signed [SPAN_W-1:0] c_col, c_row, r_ext, p_col, p_row;
	logic signed [SPAN_W-1:0] col_lo, col_hi, row_lo, row_hi;
	logic signed [SPAN_W-1:0] dx_full, dy_full;
	logic                     lit_in;

	logic                     vld_s1, lit_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;

	logic                     vld_s2, lit_s2;
	logic        [SQ_W-1:0]   dx2_s2, dy2_s2, den_s2;
	logic signed [PROD_W-1:0] dx_prod, dy_prod;
	logic        [2*RAD_W-1:0] den_prod;

	logic                     vld_s3, lit_s3;
	logic        [LEN_W-1:0]  len_s3;
	logic        [SQ_W-1:0]   den_s3;

	logic                     vld_s4, lit_s4;
	logic        [NUM_W-1:0]  num_s4;
	logic        [SQ_W-1:0]   den_s4;

	// divider stages s5 to s13
	logic                     dv_vld_s [DIV_STEPS];
	logic                     dv_lit_s [DIV_STEPS];
	logic        [NUM_W-1:0]  dv_rem_s [DIV_STEPS];
	logic        [SQ_W-1:0]   dv_den_s [DIV_STEPS];
	logic        [DIV_STEPS-1:0] dv_quo_s [DIV_STEPS];

	logic        [NUM_W-1:0]  stg_rem  [DIV_STEPS];
	logic        [SQ_W-1:0]   stg_den  [DIV_STEPS];
	logic        [DIV_STEPS-1:0] stg_quo [DIV_STEPS];
	logic        [NUM_W-1:0]  stg_dsh  [DIV_STEPS];
	logic                     stg_ge   [DIV_STEPS];

	logic                     vld_s14;
	logic        [ALPHA_W-1:0] alpha_s14;
	logic        [DIV_STEPS-1:0] quo_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			radius_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_COL: center_col_q <= cfg_data;
				REG_CENTER_ROW: center_row_q <= cfg_data;
				REG_RADIUS:     radius_q     <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = !(vld_s14 && out_stall);
	assign in_stall = vld_s14 && out_stall;

	// stage 1: offsets and square test
	always_comb begin
		c_col  = SPAN_W'(center_col_q);
		c_row  = SPAN_W'(center_row_q);
		r_ext  = $signed({{(SPAN_W-RAD_W){1'b0}}, radius_q});
		p_col  = $signed({{(SPAN_W-POS_W){1'b0}}, col});
		p_row  = $signed({{(SPAN_W-POS_W){1'b0}}, row});
		col_lo = c_col - r_ext;
		col_hi = c_col + r_ext;
		row_lo = c_row - r_ext;
		row_hi = c_row + r_ext;
		dx_full = c_col - p_col;
		dy_full = c_row - p_row;
		lit_in = (radius_q != '0) && (int'(col) < MAP_COLS) && (int'(row) < MAP_ROWS)
			&& (p_col >= col_lo) && (p_col < col_hi)
			&& (p_row >= row_lo) && (p_row < row_hi);
	end

	always_comb begin
		dx_prod  = dx_s1 * dx_s1;
		dy_prod  = dy_s1 * dy_s1;
		den_prod = radius_q * radius_q;
	end

	// divider steps: restoring, one quotient bit per stage, most significant first
	always_comb begin
		stg_rem[0] = num_s4;
		stg_den[0] = den_s4;
		stg_quo[0] = '0;
		for (int j = 1; j < DIV_STEPS; j++) begin
			stg_rem[j] = dv_rem_s[j-1];
			stg_den[j] = dv_den_s[j-1];
			stg_quo[j] = dv_quo_s[j-1];
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			stg_dsh[j] = NUM_W'(stg_den[j]) << (DIV_STEPS - 1 - j);
			stg_ge[j]  = stg_rem[j] >= stg_dsh[j];
		end
	end

	assign quo_fin = dv_quo_s[DIV_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s14 <= 1'b0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				dv_vld_s[j] <= 1'b0;
			end
		end else if (advance) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			dv_vld_s[0] <= vld_s4;
			for (int j = 1; j < DIV_STEPS; j++) begin
				dv_vld_s[j] <= dv_vld_s[j-1];
			end
			vld_s14 <= dv_vld_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lit_s1 <= lit_in;
			dx_s1  <= dx_full[DIFF_W-1:0];
			dy_s1  <= dy_full[DIFF_W-1:0];

			lit_s2 <= lit_s1;
			dx2_s2 <= dx_prod[SQ_W-1:0];
			dy2_s2 <= dy_prod[SQ_W-1:0];
			den_s2 <= den_prod;

			lit_s3 <= lit_s2;
			len_s3 <= {1'b0, dx2_s2} + {1'b0, dy2_s2};
			den_s3 <= den_s2;

			lit_s4 <= lit_s3;
			num_s4 <= {len_s3, 8'd0} - {8'd0, len_s3};
			den_s4 <= den_s3;

			dv_lit_s[0] <= lit_s4;
			for (int j = 1; j < DIV_STEPS; j++) begin
				dv_lit_s[j] <= dv_lit_s[j-1];
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				dv_rem_s[j] <= stg_ge[j] ? stg_rem[j] - stg_dsh[j] : stg_rem[j];
				dv_den_s[j] <= stg_den[j];
				dv_quo_s[j] <= {stg_quo[j][DIV_STEPS-2:0], stg_ge[j]};
			end

			if (dv_lit_s[DIV_STEPS-1] && !quo_fin[DIV_STEPS-1]) begin
				alpha_s14 <= quo_fin[ALPHA_W-1:0];
			end else begin
				alpha_s14 <= ALPHA_DARK;
			end
		end
	end

	assign out_valid = vld_s14;
	assign alpha     = alpha_s14;

endmodule

[rtl/rsam_checker.sv]
// Port-level checker for the radial spotlight alpha mask unit, bound to the top level.
// Depends on rsam_pkg and radial_spotlight_alpha_mask_unit_assert.svh.
`include "radial_spotlight_alpha_mask_unit_assert.svh"

module rsam_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rsam_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rsam_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [rsam_pkg::POS_W-1:0]          col,
	input  logic [rsam_pkg::POS_W-1:0]          row,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [rsam_pkg::ALPHA_W-1:0]        alpha
);
	import rsam_pkg::*;

	logic rad_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_zero_q <= 1'b1;
		end else if (cfg_we && (cfg_reg_t'(cfg_index) == REG_RADIUS)) begin
			rad_zero_q <= (cfg_data[RAD_W-1:0] == '0);
		end
	end

	// no light: every item comes out fully dark
	`RSAM_ASSERT_IMP(a_dark_no_light, out_valid && rad_zero_q, alpha == ALPHA_DARK)
	// input is held back only by a stalled result
	`RSAM_ASSERT_IMP(a_stall_source, in_stall, out_valid && out_stall)
	`RSAM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(alpha))

endmodule

bind radial_spotlight_alpha_mask_unit rsam_checker u_rsam_checker (.*);
